@@ src/rvx_pkg.sv @@
package rvx_pkg;

  localparam int unsigned XLEN = 32;

  // Major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [31:0] SIGN_MIN   = 32'h8000_0000;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULD = 7'h01;

  // ABI argument registers
  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A1 = 5'd11;

  // Result status codes
  localparam logic [1:0] ST_EXECUTED = 2'd0;
  localparam logic [1:0] ST_ILLEGAL  = 2'd1;
  localparam logic [1:0] ST_ECALL    = 2'd2;

  // Divider handshake
  typedef struct packed {
    logic             start;
    logic [XLEN-1:0]  dividend;
    logic [XLEN-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [XLEN-1:0]  quot;
    logic [XLEN-1:0]  rem;
  } div_rsp_t;

endpackage

@@ src/rvx_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
module rvx_div
  import rvx_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(XLEN);

  logic            busy_q;
  logic            done_q;
  logic [CW-1:0]   cnt_q;
  logic [XLEN:0]   rem_q;
  logic [XLEN-1:0] quo_q;
  logic [XLEN-1:0] dvs_q;

  logic [XLEN:0]   rem_sh;
  logic [XLEN:0]   rem_sub;
  logic            fits;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem_q[XLEN-1:0], quo_q[XLEN-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(XLEN-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub : rem_sh;
      quo_q <= {quo_q[XLEN-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q[XLEN-1:0];

endmodule

@@ src/rv32im_instruction_executor.sv @@
// RV32IM executor: one instruction word per input transfer, one result per
// output transfer. After reset the data memory is swept to zero, one byte per
// cycle, before the first instruction is taken. Registers are read at the
// input transfer, most instructions execute in the next cycle and the
// result is registered when execution completes and held until taken. The
// input is not ready from the input transfer until the result transfer, so
// instructions do not overlap: input transfer, execute and output transfer
// follow in turn. Loads and stores walk the memory port one byte at a time;
// a loaded byte waits for the registered read data, a stored byte is
// written directly. Divide and remainder by a nonzero divisor use a
// bit-serial divider. When MEM_BYTES is not a power of two the first byte
// address is reduced by a reciprocal multiply and one fold.
module rv32im_instruction_executor
  import rvx_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] instruction_word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // [1:0] status, [33:2] next_pc,
                                       // [34] rd_written, [39:35] rd_index,
                                       // [71:40] rd_value,
                                       // [103:72] call_service,
                                       // [135:104] call_argument
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam bit          POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);
  localparam logic [31:0] MOD_W = 32'(MEM_BYTES);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(MEM_BYTES));

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_DIV, S_MOD, S_MEM, S_OUT
  } state_e;

  typedef enum logic [1:0] {K_DONE, K_MEM, K_DIV} kind_e;

  state_e       state_q;
  logic [31:0]  instr_q;
  logic [31:0]  pc_q;
  logic [31:0]  a_raw_q, b_raw_q;
  logic         a_vld_q, b_vld_q;
  logic [31:0]  addr_q;
  logic [AW-1:0] idx_q;
  logic [1:0]   cnt_q;
  logic         ph_q;
  logic [31:0]  ld_q;
  logic [31:0]  red_q;
  logic         neg_a_q, neg_b_q;

  // result registers
  logic [1:0]   status_q;
  logic [31:0]  npc_q;
  logic         wr_q;
  logic [4:0]   rd_q;
  logic [31:0]  val_q;
  logic [31:0]  svc_q, arg_q;

  // register file and valid bits
  logic [31:0]  rf_mem [32];
  logic [31:0]  rf_vld_q;
  logic [4:0]   ra, rb;
  logic         rf_we;

  // data memory
  logic [7:0]   dmem [MEM_BYTES];
  logic [7:0]   mem_rd_q;
  logic         mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]   mem_wdata;

  div_req_t     div_req;
  div_rsp_t     div_rsp;

  // decode fields
  logic [31:0]  w, a, b;
  logic [6:0]   op, f7;
  logic [2:0]   f3;
  logic [4:0]   rd;
  logic [31:0]  imm_i, imm_s, imm_b, imm_j, imm_u, opb;
  logic [65:0]  prod;
  logic         s_acc, m_acc;

  // exec outcome
  kind_e        kind;
  logic         x_ok, x_wr;
  logic [31:0]  x_val, x_npc, ea;
  logic         x_ecall;
  logic         taken;

  // finish path
  logic         fin;
  logic         f_ok, f_wr;
  logic [31:0]  f_val, f_npc;
  logic         wr_eff;

  logic [1:0]   last_cnt;
  logic [31:0]  ld_next, ld_val, raw_next;
  logic [31:0]  q_fix, r_fix;
  logic [AW-1:0] idx_next;
  logic [63:0]  red_prod;
  logic [31:0]  red_rem, red_fold;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {arg_q, svc_q, val_q, rd_q, wr_q, npc_q, status_q};

  // register read addresses: an ecall reads a0 and a1
  always_comb begin
    if (s_axis_tdata == ECALL_WORD) begin
      ra = REG_A0;
      rb = REG_A1;
    end else begin
      ra = s_axis_tdata[19:15];
      rb = s_axis_tdata[24:20];
    end
  end

  always_comb begin
    w     = instr_q;
    op    = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    f7    = w[31:25];
    a     = a_vld_q ? a_raw_q : '0;
    b     = b_vld_q ? b_raw_q : '0;
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm_u = {w[31:12], 12'b0};
    opb   = (op == OP_IMM) ? imm_i : b;
    prod  = $signed({(f3[1:0] != 2'd3) & a[31], a})
          * $signed({(f3[1:0] == 2'd1) & b[31], b});
  end

  // execute stage: shared ALU, branch compare, address add
  always_comb begin
    kind    = K_DONE;
    x_ok    = 1'b1;
    x_wr    = 1'b0;
    x_val   = '0;
    x_npc   = pc_q + 32'd4;
    x_ecall = 1'b0;
    taken   = 1'b0;
    ea      = a + ((op == OP_STORE) ? imm_s : imm_i);
    unique case (op)
      OP_REG, OP_IMM: begin
        x_wr = 1'b1;
        if (op == OP_REG && f7 == F7_MULD) begin
          if (!f3[2]) begin
            x_val = (f3 == 3'd0) ? prod[31:0] : prod[63:32];
          end else if (b == '0) begin
            x_val = f3[1] ? a : '1;
          end else begin
            kind = K_DIV;
          end
        end else if (op == OP_REG && f7 != F7_BASE
                     && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
          x_ok = 1'b0;
        end else begin
          case (f3)
            3'd0: x_val = (op == OP_REG && f7 == F7_ALT) ? a - opb : a + opb;
            3'd1: begin
              x_val = a << opb[4:0];
              if (op == OP_IMM && f7 != F7_BASE) x_ok = 1'b0;
            end
            3'd2: x_val = {31'b0, $signed(a) < $signed(opb)};
            3'd3: x_val = {31'b0, a < opb};
            3'd4: x_val = a ^ opb;
            3'd5: begin
              if (f7 == F7_ALT) x_val = 32'($signed(a) >>> opb[4:0]);
              else x_val = a >> opb[4:0];
              if (op == OP_IMM && f7 != F7_BASE && f7 != F7_ALT) x_ok = 1'b0;
            end
            3'd6: x_val = a | opb;
            default: x_val = a & opb;
          endcase
        end
      end
      OP_LOAD: begin
        x_wr = 1'b1;
        if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) kind = K_MEM;
        else x_ok = 1'b0;
      end
      OP_STORE: begin
        if (f3 <= 3'd2) kind = K_MEM;
        else x_ok = 1'b0;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: x_ok = 1'b0;
        endcase
        if (taken) x_npc = pc_q + imm_b;
      end
      OP_JALR: begin
        if (f3 != 3'd0) x_ok = 1'b0;
        x_wr  = 1'b1;
        x_val = pc_q + 32'd4;
        x_npc = (a + imm_i) & ~32'd1;
      end
      OP_JAL: begin
        x_wr  = 1'b1;
        x_val = pc_q + 32'd4;
        x_npc = pc_q + imm_j;
      end
      OP_LUI: begin
        x_wr  = 1'b1;
        x_val = imm_u;
      end
      OP_AUIPC: begin
        x_wr  = 1'b1;
        x_val = pc_q + imm_u;
      end
      OP_SYSTEM: begin
        if (w == ECALL_WORD) x_ecall = 1'b1;
        else x_ok = 1'b0;
      end
      default: x_ok = 1'b0;
    endcase
    if (!x_ok) kind = K_DONE;
  end

  // byte walk helpers, divider sign fix-up, address reduction
  always_comb begin
    last_cnt = f3[1] ? 2'd3 : {1'b0, f3[0]};
    ld_next  = ld_q;
    ld_next[{cnt_q, 3'b000} +: 8] = mem_rd_q;
    case (f3)
      3'd0:    ld_val = {{24{ld_next[7]}}, ld_next[7:0]};
      3'd1:    ld_val = {{16{ld_next[15]}}, ld_next[15:0]};
      3'd4:    ld_val = {24'b0, ld_next[7:0]};
      3'd5:    ld_val = {16'b0, ld_next[15:0]};
      default: ld_val = ld_next;
    endcase
    raw_next = addr_q + {30'b0, cnt_q} + 32'd1;
    if (raw_next == '0 || idx_q == AW'(MEM_BYTES - 1)) idx_next = '0;
    else idx_next = idx_q + 1'b1;
    q_fix = (neg_a_q ^ neg_b_q) ? -div_rsp.quot : div_rsp.quot;
    r_fix = neg_a_q ? -div_rsp.rem : div_rsp.rem;
    // address reduction: the quotient estimate is low by at most one
    red_prod = 64'(addr_q) * 64'(RECIP);
    red_rem  = addr_q - red_q * MOD_W;
    red_fold = (red_q >= MOD_W) ? red_q - MOD_W : red_q;
  end

  // memory port and divider requests
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = b[{cnt_q, 3'b000} +: 8];
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (state_q == S_MEM && op == OP_STORE) begin
      mem_we = 1'b1;
    end
    div_req.start    = (state_q == S_EXEC && kind == K_DIV);
    div_req.dividend = (!f3[0] && a[31]) ? -a : a;
    div_req.divisor  = (!f3[0] && b[31]) ? -b : b;
  end

  // completion of an instruction
  always_comb begin
    fin   = 1'b0;
    f_ok  = x_ok;
    f_wr  = x_wr;
    f_val = x_val;
    f_npc = x_npc;
    if (state_q == S_EXEC && kind == K_DONE) begin
      fin = 1'b1;
    end else if (state_q == S_DIV && div_rsp.done) begin
      fin   = 1'b1;
      f_val = f3[1] ? r_fix : q_fix;
    end else if (state_q == S_MEM && cnt_q == last_cnt
                 && (op == OP_STORE || ph_q)) begin
      fin   = 1'b1;
      f_val = ld_val;
    end
    if (!f_ok) begin
      f_wr  = 1'b0;
      f_npc = pc_q;
    end
    wr_eff = f_wr && (rd != '0);
  end

  assign rf_we = fin && wr_eff;

  // register file storage
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rd] <= f_val;
    if (s_acc) begin
      a_raw_q <= rf_mem[ra];
      b_raw_q <= rf_mem[rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
    end else begin
      if (rf_we) rf_vld_q[rd] <= 1'b1;
      if (s_acc) begin
        a_vld_q <= rf_vld_q[ra];
        b_vld_q <= rf_vld_q[rb];
      end
    end
  end

  // data memory
  always_ff @(posedge clk_i) begin
    if (mem_we) dmem[mem_addr] <= mem_wdata;
    mem_rd_q <= dmem[mem_addr];
  end

  rvx_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer with registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      pc_q     <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      ph_q     <= 1'b0;
      red_q    <= '0;
      instr_q  <= '0;
      status_q <= ST_EXECUTED;
      npc_q    <= '0;
      wr_q     <= 1'b0;
      rd_q     <= '0;
      val_q    <= '0;
      svc_q    <= '0;
      arg_q    <= '0;
      addr_q   <= '0;
      ld_q     <= '0;
      neg_a_q  <= 1'b0;
      neg_b_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == AW'(MEM_BYTES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_acc) begin
            instr_q <= s_axis_tdata;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          addr_q   <= ea;
          cnt_q    <= '0;
          ph_q     <= 1'b0;
          ld_q     <= '0;
          neg_a_q  <= !f3[0] && a[31];
          neg_b_q  <= !f3[0] && b[31];
          if (kind == K_DIV) begin
            state_q <= S_DIV;
          end else if (kind == K_MEM) begin
            if (POW2) begin
              idx_q   <= ea[AW-1:0];
              state_q <= S_MEM;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_DIV: begin
        end
        // quotient estimate, remainder, one fold
        S_MOD: begin
          if (cnt_q == 2'd2) begin
            idx_q   <= red_fold[AW-1:0];
            cnt_q   <= '0;
            state_q <= S_MEM;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            red_q <= (cnt_q == 2'd0) ? red_prod[63:32] : red_rem;
          end
        end
        S_MEM: begin
          if (op == OP_STORE || ph_q) begin
            ld_q  <= ld_next;
            cnt_q <= cnt_q + 1'b1;
            idx_q <= idx_next;
            ph_q  <= 1'b0;
          end else begin
            ph_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (m_acc) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (fin) begin
        state_q  <= S_OUT;
        pc_q     <= f_npc;
        npc_q    <= f_npc;
        wr_q     <= wr_eff;
        rd_q     <= wr_eff ? rd : '0;
        val_q    <= wr_eff ? f_val : '0;
        status_q <= !f_ok ? ST_ILLEGAL : (x_ecall ? ST_ECALL : ST_EXECUTED);
        svc_q    <= (f_ok && x_ecall) ? a : '0;
        arg_q    <= (f_ok && x_ecall) ? b : '0;
      end
    end
  end

  // checks
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rd != 5'd0)
    else $error("write to x0");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("ready right after accept");

  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status_q == ST_ILLEGAL) |-> (!wr_q && npc_q == pc_q))
    else $error("illegal instruction changed state");

  a_mem_only_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_MEM))
    else $error("memory write outside clear or store");

endmodule

@@ test/rv32im_instruction_executor_tb.sv @@
module rv32im_instruction_executor_tb;
  import rvx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_SIZE = 65536;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] arg;
    logic [31:0] svc;
    logic [31:0] val;
    logic [4:0]  rd;
    logic        wr;
    logic [31:0] npc;
    logic [1:0]  status;
  } exec_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;   // [31:0] instruction_word
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;   // status, next_pc, rd_written, rd_index, rd_value, svc, arg

  rv32im_instruction_executor dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor state
  logic [31:0]  gpr [32];
  logic [31:0]  pc_q;
  logic [7:0]   dmem [MEM_SIZE];
  exec_result_t pending_results [$];
  int unsigned  n_errors;
  int unsigned  n_sent;
  int unsigned  n_checked;
  longint unsigned cycle_cnt;
  bit           rx_stall_on;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] load_bytes(logic [31:0] a, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v[8*i +: 8] = dmem[(a + i) % MEM_SIZE];
    return v;
  endfunction

  // Execute one word against the shadow state
  function automatic exec_result_t execute_word(logic [31:0] w);
    exec_result_t r;
    logic [6:0]  op, f7;
    logic [4:0]  rd, sh;
    logic [2:0]  f3;
    logic [31:0] a, b, npc, val, off, addr;
    logic [63:0] p;
    bit ok, wr, t;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = gpr[w[19:15]]; b = gpr[w[24:20]];
    npc = pc_q + 4; val = '0; ok = 1; wr = 0; t = 0;
    r = '0;
    case (op)
      OP_REG: begin
        wr = 1; sh = b[4:0];
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << sh;
            3'd2: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: val = (a < b) ? 32'd1 : 32'd0;
            3'd4: val = a ^ b;
            3'd5: val = a >> sh;
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) val = a - b;
        else if (f7 == F7_ALT && f3 == 3'd5) val = $signed(a) >>> sh;
        else if (f7 == F7_MULD) begin
          case (f3)
            3'd0: val = a * b;
            3'd1: begin p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}); val = p[63:32]; end
            3'd2: begin p = {{32{a[31]}}, a} * {32'd0, b}; val = p[63:32]; end
            3'd3: begin p = {32'd0, a} * {32'd0, b}; val = p[63:32]; end
            3'd4: begin
              if (b == 0) val = '1;
              else if (a == SIGN_MIN && b == '1) val = SIGN_MIN;
              else val = $signed(a) / $signed(b);
            end
            3'd5: val = (b == 0) ? '1 : a / b;
            3'd6: begin
              if (b == 0) val = a;
              else if (a == SIGN_MIN && b == '1) val = 32'd0;
              else val = $signed(a) % $signed(b);
            end
            default: val = (b == 0) ? a : a % b;
          endcase
        end else ok = 0;
      end
      OP_IMM: begin
        wr = 1; off = sx(w[31:20], 12); sh = w[24:20];
        case (f3)
          3'd0: val = a + off;
          3'd1: if (f7 != 0) ok = 0; else val = a << sh;
          3'd2: val = ($signed(a) < $signed(off)) ? 32'd1 : 32'd0;
          3'd3: val = (a < off) ? 32'd1 : 32'd0;
          3'd4: val = a ^ off;
          3'd5: if (f7 == F7_BASE) val = a >> sh;
                else if (f7 == F7_ALT) val = $signed(a) >>> sh;
                else ok = 0;
          3'd6: val = a | off;
          default: val = a & off;
        endcase
      end
      OP_LOAD: begin
        wr = 1; addr = a + sx(w[31:20], 12);
        case (f3)
          3'd0: val = sx(load_bytes(addr, 1), 8);
          3'd1: val = sx(load_bytes(addr, 2), 16);
          3'd2: val = load_bytes(addr, 4);
          3'd4: val = load_bytes(addr, 1);
          3'd5: val = load_bytes(addr, 2);
          default: ok = 0;
        endcase
      end
      OP_STORE: begin
        if (f3 > 3'd2) ok = 0;
        else begin
          addr = a + sx({w[31:25], w[11:7]}, 12);
          for (int i = 0; i < (1 << f3); i++) dmem[(addr + i) % MEM_SIZE] = b[8*i +: 8];
        end
      end
      OP_BRANCH: begin
        off = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        case (f3)
          3'd0: t = (a == b);
          3'd1: t = (a != b);
          3'd4: t = $signed(a) < $signed(b);
          3'd5: t = !($signed(a) < $signed(b));
          3'd6: t = a < b;
          3'd7: t = a >= b;
          default: ok = 0;
        endcase
        if (t) npc = pc_q + off;
      end
      OP_JALR: begin
        if (f3 != 0) ok = 0;
        else begin
          val = pc_q + 4; wr = 1;
          npc = (a + sx(w[31:20], 12)) & ~32'd1;
        end
      end
      OP_JAL: begin
        val = pc_q + 4; wr = 1;
        npc = pc_q + sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
      end
      OP_LUI:   begin val = {w[31:12], 12'd0}; wr = 1; end
      OP_AUIPC: begin val = pc_q + {w[31:12], 12'd0}; wr = 1; end
      OP_SYSTEM: begin
        if (w != ECALL_WORD) ok = 0;
        else begin
          r.status = ST_ECALL; r.svc = gpr[REG_A0]; r.arg = gpr[REG_A1];
        end
      end
      default: ok = 0;
    endcase
    if (!ok) begin
      r = '0; r.status = ST_ILLEGAL; npc = pc_q; wr = 0;
    end
    if (wr && rd != 0) begin
      gpr[rd] = val; r.wr = 1; r.rd = rd; r.val = val;
    end
    pc_q = npc;
    r.npc = npc;
    return r;
  endfunction

  // Short gaps mostly, occasionally long
  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays up after a transfer unless a gap or a drain follows
  task automatic send_word(logic [31:0] w);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(execute_word(w));
    n_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction
  function automatic logic [31:0] enc_i(logic [6:0] op, logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, op};
  endfunction
  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction
  function automatic logic [31:0] enc_lui(logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, OP_LUI};
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    exec_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status); n_errors++;
        end
        if (got.npc !== want.npc) begin
          $display("%0t: next_pc exp %h got %h", $realtime, want.npc, got.npc); n_errors++;
        end
        if (got.wr !== want.wr) begin
          $display("%0t: rd_written exp %0d got %0d", $realtime, want.wr, got.wr); n_errors++;
        end
        if (got.rd !== want.rd) begin
          $display("%0t: rd_index exp %0d got %0d", $realtime, want.rd, got.rd); n_errors++;
        end
        if (got.val !== want.val) begin
          $display("%0t: rd_value exp %h got %h", $realtime, want.val, got.val); n_errors++;
        end
        if (got.svc !== want.svc) begin
          $display("%0t: call_service exp %h got %h", $realtime, want.svc, got.svc); n_errors++;
        end
        if (got.arg !== want.arg) begin
          $display("%0t: call_argument exp %h got %h", $realtime, want.arg, got.arg); n_errors++;
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    if (!rx_stall_on) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("rv32im_instruction_executor_tb: errors");
      $finish;
    end
  end

  // Directed: extremes, a selection of operations, special cases
  task automatic test_directed();
    send_word(enc_lui(20'hFFFFF, 5'd1));                      // x1 = 0xFFFFF000
    send_word(enc_i(OP_IMM, 12'hFFF, 5'd1, 3'd6, 5'd1));      // x1 = -1
    send_word(enc_lui(20'h80000, 5'd2));                      // x2 = min
    send_word(enc_r(F7_MULD, 5'd1, 5'd2, 3'd4, 5'd3));        // div overflow
    send_word(enc_r(F7_MULD, 5'd1, 5'd2, 3'd6, 5'd4));        // rem overflow
    send_word(enc_r(F7_MULD, 5'd0, 5'd2, 3'd5, 5'd5));        // divu by zero
    send_word(enc_r(F7_MULD, 5'd0, 5'd2, 3'd7, 5'd6));        // remu by zero
    send_word(enc_r(F7_MULD, 5'd1, 5'd2, 3'd1, 5'd7));        // mulh
    send_word(enc_r(F7_MULD, 5'd1, 5'd1, 3'd3, 5'd8));        // mulhu
    send_word(enc_r(F7_ALT, 5'd1, 5'd2, 3'd5, 5'd9));         // sra by 31
    send_word(enc_r(F7_BASE, 5'd1, 5'd1, 3'd0, 5'd0));        // write to x0
    send_word(enc_s(12'hFFF, 5'd2, 5'd0, 3'd2));              // sw at wrapped address
    send_word(enc_i(OP_LOAD, 12'hFFF, 5'd0, 3'd2, 5'd10));    // lw back
    send_word(enc_i(OP_LOAD, 12'hFFE, 5'd0, 3'd0, 5'd11));    // lb wrap
    send_word(enc_i(OP_IMM, 12'h41F, 5'd2, 3'd5, 5'd12));     // srai 31
    send_word(enc_i(OP_IMM, 12'h21F, 5'd2, 3'd5, 5'd12));     // bad shift upper bits
    send_word(enc_i(OP_IMM, 12'h03F, 5'd2, 3'd1, 5'd12));     // bad slli
    send_word(enc_i(OP_JALR, 12'h001, 5'd1, 3'd1, 5'd13));    // jalr bad funct3
    send_word(32'h0010_0073);                                 // ebreak: illegal
    send_word(ECALL_WORD);
    send_word(enc_i(OP_JALR, 12'h7FF, 5'd2, 3'd0, 5'd14));    // jalr odd target
    send_word({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd15, OP_JAL});   // jal back
    send_word({20'h12345, 5'd16, OP_AUIPC});
    send_word({7'h7F, 5'd1, 5'd2, 3'd2, 5'h1F, OP_BRANCH});   // bad branch funct3
    send_word(32'hFFFF_FFFF);
  endtask

  function automatic logic [4:0] small_reg();
    return $urandom_range(0, 7) == 0 ? 5'($urandom) : 5'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] rand_word();
    int unsigned k;
    logic [11:0] imm;
    k = $urandom_range(0, 99);
    imm = 12'($urandom);
    if (k < 22) return enc_r(($urandom_range(0, 2) == 0) ? F7_MULD
                             : ($urandom_range(0, 1) ? F7_ALT : F7_BASE),
                             small_reg(), small_reg(), 3'($urandom), small_reg());
    if (k < 40) return enc_i(OP_IMM, imm, small_reg(), 3'($urandom), small_reg());
    if (k < 48) return enc_lui(20'($urandom), small_reg());
    if (k < 58) return enc_i(OP_LOAD, imm, small_reg(), 3'($urandom_range(0, 5)), small_reg());
    if (k < 70) return enc_s(imm, small_reg(), small_reg(), 3'($urandom_range(0, 3)));
    if (k < 78) return {7'($urandom), small_reg(), small_reg(), 3'($urandom), 5'($urandom),
                        OP_BRANCH};
    if (k < 82) return enc_i(OP_JALR, imm, small_reg(), ($urandom_range(0, 5) == 0) ?
                             3'($urandom) : 3'd0, small_reg());
    if (k < 86) return {20'($urandom), small_reg(), OP_JAL};
    if (k < 89) return {20'($urandom), small_reg(), OP_AUIPC};
    if (k < 93) return ($urandom_range(0, 2) == 0) ? 32'($urandom) | 32'h73 : ECALL_WORD;
    return $urandom;
  endfunction

  task automatic test_random(int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_word(rand_word());
      if (i == count / 2) wait_drained();  // sender hold-off until drained
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b1;
    rx_stall_on   = 0;
    n_errors = 0; n_sent = 0; n_checked = 0; cycle_cnt = 0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    pc_q = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(250);
    rx_stall_on = 1;
    test_random(500);
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d instruction words, checked %0d results (ALU, M ops, memory,", n_sent,
             n_checked);
    $display("control flow, ecall, illegal encodings) under random stalls.");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("rv32im_instruction_executor_tb: clean");
    end else begin
      $display("rv32im_instruction_executor_tb: errors");
    end
    $finish;
  end

endmodule
